// File: src/ppnm_pkg.sv
// Shared constants, types and helpers for the play-position notify matcher.
package ppnm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int OFFSET_BITS = 28;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int END_W       = OFFSET_BITS + 1;
  localparam int ENTRY_W     = OFFSET_BITS + 1;
  localparam int DIV_CNT_W   = $clog2(END_W + 1);
  localparam int NOTIFY_W    = 7;
  localparam int CFG_W       = 28;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_COUNT  = 1'd1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  localparam logic [OFFSET_BITS-1:0] BUFFER_LENGTH_RESET = OFFSET_BITS'(65536);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STOP_SCAN,
    ST_FIRST_SCAN,
    ST_SEARCH,
    ST_FWD_SCAN,
    ST_WRAP_SCAN,
    ST_FINISH
  } state_t;

  // Midpoint of a search window, rounded down
  function automatic logic [CNT_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                              input logic [CNT_W-1:0] hi);
    logic [CNT_W:0] sum;
    sum = {1'b0, lo} + {1'b0, hi};
    return sum[CNT_W:1];
  endfunction

endpackage

// File: src/play_position_notify_matcher.sv
// Play-position notify matcher: entry table in RAM, span check sequencer.
//
// Usage: the input channel (in_valid/in_ready) carries write items and check
// items. A write item stores one table entry in the cycle it is accepted and
// gives no result. A check item returns one or more result items on the
// output channel (out_valid/out_ready), the final one with last set; a check
// that fires nothing returns one result with signalled low.
// The config port (cfg_wr_en, cfg_index, cfg_data) writes buffer_length and
// notify_count with no handshake; write it only while the block is idle.
// When stopped, a check fires the leading stop entries; otherwise it skips them
// and, unless every entry is a stop entry, a binary search (up to 7 steps for
// 64 entries) finds the first entry not below the position, and a forward scan
// fires entries below the span end. A wrapped span then fires entries from the
// front, and those reads wait for the bit-serial remainder unit. The single
// table read port sets the one-entry-per-cycle scan while the output does not
// stall and the remainder is not awaited.
// One item is in work at a time; the next item is accepted once the final
// result sits in the output register. A stalled receiver holds the output
// register and stalls the scan. Reset restores buffer_length to 65536 and
// notify_count to 0; the table is undefined until written.
module play_position_notify_matcher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [ppnm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppnm_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [ppnm_pkg::IDX_W-1:0]    entry_index,
  input  logic [ppnm_pkg::OFFSET_BITS-1:0] entry_offset,
  input  logic                          entry_is_stop,
  input  logic [ppnm_pkg::OFFSET_BITS-1:0] play_position,
  input  logic [ppnm_pkg::OFFSET_BITS-1:0] span_length,
  input  logic                          is_stopped,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ppnm_pkg::IDX_W-1:0]    event_index,
  output logic                          signalled,
  output logic                          last
);
  import ppnm_pkg::*;

  // Configuration registers
  logic [OFFSET_BITS-1:0] buf_len;
  logic [NOTIFY_W-1:0]    notify_count;

  // Sequencer state
  state_t         state, state_next;
  logic [CNT_W-1:0] idx;
  logic           rd_pend;
  logic [CNT_W-1:0] first;
  logic [CNT_W-1:0] lo, hi;
  logic [OFFSET_BITS-1:0] pos;
  logic [END_W-1:0] end_pos;

  // Pending result, held until the next one shows whether it is the last
  logic           pend_vld;
  logic [IDX_W-1:0] pend_idx;

  // Remainder unit
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [END_W-1:0]       div_num;
  logic [OFFSET_BITS-1:0] div_rem;
  logic [END_W-1:0]       div_trial;
  logic                   div_done;

  // Table memory
  logic               ram_we;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [OFFSET_BITS-1:0] rd_off;
  logic               rd_stop;

  // Step control
  logic in_acc;
  logic out_free;
  logic can_emit;
  logic emit_req;
  logic step_adv;
  logic step_end;
  logic cont;
  logic push_pend;
  logic push_final;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] bound;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] lo_n, hi_n;
  logic below_pos, below_end, below_wend;
  logic wrap_need;

  ppnm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_index),
    .wdata ({entry_is_stop, entry_offset}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign ram_we   = in_acc && (req_type == REQ_WRITE);

  assign rd_off  = ram_rdata[OFFSET_BITS-1:0];
  assign rd_stop = ram_rdata[OFFSET_BITS];

  assign n_eff = (CNT_W'(notify_count) > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                              : CNT_W'(notify_count);
  assign bound   = (state == ST_WRAP_SCAN) ? lo : n_eff;
  assign idx_inc = idx + CNT_W'(1);

  // Entry compares; a stop entry is never below any limit
  assign below_pos  = !rd_stop && (rd_off < pos);
  assign below_end  = !rd_stop && ({1'b0, rd_off} < end_pos);
  assign below_wend = !rd_stop && (rd_off < div_rem);
  assign wrap_need  = (buf_len != '0) && (end_pos > {1'b0, buf_len});

  // Search window after evaluating the entry read at idx
  assign lo_n = below_pos ? idx_inc : lo;
  assign hi_n = below_pos ? hi : idx;

  assign out_free = !out_valid || out_ready;
  assign can_emit = !pend_vld || out_free;

  // Remainder step
  assign div_trial = {div_rem, div_num[END_W-1]};
  assign div_done  = (div_cnt == '0);

  // Drive reads and decide each step
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx[IDX_W-1:0];
    emit_req  = 1'b0;
    step_adv  = 1'b0;
    step_end  = 1'b0;
    cont      = 1'b0;
    case (state)
      ST_STOP_SCAN, ST_FIRST_SCAN, ST_FWD_SCAN, ST_WRAP_SCAN: begin
        if (!rd_pend) begin
          if (idx >= bound) begin
            step_end = 1'b1;
          end else if (state != ST_WRAP_SCAN || div_done) begin
            ram_re = 1'b1;
          end
        end else begin
          case (state)
            ST_STOP_SCAN:  cont = rd_stop;
            ST_FIRST_SCAN: cont = rd_stop;
            ST_FWD_SCAN:   cont = below_end;
            default:       cont = below_wend;
          endcase
          if (cont) begin
            emit_req = (state != ST_FIRST_SCAN);
            if (!emit_req || can_emit) begin
              step_adv  = 1'b1;
              ram_re    = (idx_inc < bound);
              ram_raddr = idx_inc[IDX_W-1:0];
            end
          end else begin
            step_end = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        if (!rd_pend) begin
          if (lo < hi) begin
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(mid_of(lo, hi));
          end else begin
            step_end = 1'b1;
          end
        end else if (lo_n < hi_n) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(mid_of(lo_n, hi_n));
        end else begin
          step_end = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign push_pend  = emit_req && step_adv && pend_vld;
  assign push_final = (state == ST_FINISH) && out_free;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && req_type == REQ_CHECK) begin
          state_next = is_stopped ? ST_STOP_SCAN : ST_FIRST_SCAN;
        end
      end
      ST_STOP_SCAN: begin
        if (step_end) state_next = ST_FINISH;
      end
      ST_FIRST_SCAN: begin
        if (step_end) state_next = rd_pend ? ST_SEARCH : ST_FINISH;
      end
      ST_SEARCH: begin
        if (step_end) state_next = ST_FWD_SCAN;
      end
      ST_FWD_SCAN: begin
        if (step_end) state_next = wrap_need ? ST_WRAP_SCAN : ST_FINISH;
      end
      ST_WRAP_SCAN: begin
        if (step_end) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rd_pend      <= 1'b0;
      pend_vld     <= 1'b0;
      out_valid    <= 1'b0;
      div_cnt      <= '0;
      buf_len      <= BUFFER_LENGTH_RESET;
      notify_count <= '0;
    end else begin
      state <= state_next;

      // Config writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_BUFFER_LENGTH: buf_len      <= cfg_data[OFFSET_BITS-1:0];
          REG_NOTIFY_COUNT:  notify_count <= cfg_data[NOTIFY_W-1:0];
          default: begin
          end
        endcase
      end

      // Track outstanding table read
      if (in_acc) begin
        rd_pend <= 1'b0;
      end else if (ram_re) begin
        rd_pend <= 1'b1;
      end else if (step_adv || step_end) begin
        rd_pend <= 1'b0;
      end

      // Pending result
      if (in_acc || push_final) begin
        pend_vld <= 1'b0;
      end else if (emit_req && step_adv) begin
        pend_vld <= 1'b1;
      end

      // Output register
      if (push_pend || push_final) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // Remainder unit: one quotient bit a cycle
      if (in_acc && req_type == REQ_CHECK) begin
        div_cnt <= DIV_CNT_W'(END_W);
      end else if (!div_done) begin
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && req_type == REQ_CHECK) begin
      pos     <= play_position;
      end_pos <= {1'b0, play_position} + {1'b0, span_length};
      idx     <= '0;
      div_num <= {1'b0, play_position} + {1'b0, span_length};
      div_rem <= '0;
    end else begin
      if (!div_done) begin
        div_num <= {div_num[END_W-2:0], 1'b0};
        if (div_trial >= {1'b0, buf_len}) begin
          div_rem <= OFFSET_BITS'(div_trial - {1'b0, buf_len});
        end else begin
          div_rem <= div_trial[OFFSET_BITS-1:0];
        end
      end

      case (state)
        ST_SEARCH: begin
          if (rd_pend) begin
            lo <= lo_n;
            hi <= hi_n;
          end
          if (ram_re) begin
            idx <= CNT_W'(ram_raddr);
          end else if (step_end) begin
            idx <= rd_pend ? lo_n : lo;
          end
        end
        ST_FIRST_SCAN: begin
          if (step_adv) begin
            idx <= idx_inc;
          end else if (step_end && rd_pend) begin
            first <= idx;
            lo    <= idx;
            hi    <= n_eff;
          end
        end
        ST_FWD_SCAN: begin
          if (step_adv) begin
            idx <= idx_inc;
          end else if (step_end) begin
            idx <= first;
          end
        end
        ST_STOP_SCAN, ST_WRAP_SCAN: begin
          if (step_adv) begin
            idx <= idx_inc;
          end
        end
        default: begin
        end
      endcase
    end

    // Hold the newest fired entry
    if (emit_req && step_adv) begin
      pend_idx <= idx[IDX_W-1:0];
    end

    // Load output payload
    if (push_pend) begin
      event_index <= pend_idx;
      signalled   <= 1'b1;
      last        <= 1'b0;
    end else if (push_final) begin
      event_index <= pend_vld ? pend_idx : '0;
      signalled   <= pend_vld;
      last        <= 1'b1;
    end
  end

endmodule

// File: src/ppnm_ram.sv
// Generic single-port-write, registered-read RAM.
module ppnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; data holds when no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: tb/tb_play_position_notify_matcher.sv
// Testbench for the play-position notify matcher: directed table, random phases, scoreboard.
module tb_play_position_notify_matcher;
  import ppnm_pkg::*;

  localparam int          RANDOM_ITEMS   = 470;
  localparam int          SETTLE_CYCLES  = 48;
  localparam int          RX_HOLD_CYCLES = 300;
  localparam int unsigned LIMIT_CYCLES   = 2_000_000;
  localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_CHECK,
    ROW_CONFIG
  } row_kind_t;

  // One directed row: write uses sel/val_a/flag as slot/offset/stop, check uses
  // val_a/val_b/flag as position/span/stopped, config uses val_a/val_b as
  // buffer length/count. A typed row carries its single expected result.
  typedef struct packed {
    row_kind_t              kind;
    logic [IDX_W-1:0]       sel;
    logic [OFFSET_BITS-1:0] val_a;
    logic [OFFSET_BITS-1:0] val_b;
    logic                   flag;
    logic                   typed;
    logic [IDX_W-1:0]       t_idx;
    logic                   t_sig;
  } dir_row_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             signalled;
    logic             last;
  } event_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   req_type = REQ_WRITE;
  logic [IDX_W-1:0]       entry_index = '0;
  logic [OFFSET_BITS-1:0] entry_offset = '0;
  logic                   entry_is_stop = 1'b0;
  logic [OFFSET_BITS-1:0] play_position = '0;
  logic [OFFSET_BITS-1:0] span_length = '0;
  logic                   is_stopped = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [IDX_W-1:0]       event_index;
  logic                   signalled;
  logic                   last;

  // Shadow of the block: entry table, written mask and registers
  logic [OFFSET_BITS-1:0] shadow_ofs [TABLE_DEPTH];
  logic                   shadow_stop [TABLE_DEPTH];
  bit                     written [TABLE_DEPTH];
  logic [OFFSET_BITS-1:0] ring_len = BUFFER_LENGTH_RESET;
  logic [NOTIFY_W-1:0]    entry_count = '0;

  event_t due_events[$];
  int     errors = 0;
  int     items_sent = 0;
  int     tx_idle_pct = 8;
  int     rx_idle_pct = 8;
  int     hold_asked = 0;
  int     hold_served = 0;
  int     rx_hold_left = 0;

  dir_row_t directed [22] = '{
    // empty table: both modes give one empty result
    '{ROW_CHECK,  6'd0, 28'd0,          28'd0,          1'b0, 1'b1, 6'd0, 1'b0},
    '{ROW_CHECK,  6'd0, 28'hFFFFFFF,    28'hFFFFFFF,    1'b1, 1'b1, 6'd0, 1'b0},
    // two leading stop entries, then ascending offsets with a duplicate
    '{ROW_WRITE,  6'd0, 28'hFFFFFFF,    28'd0,          1'b1, 1'b0, 6'd0, 1'b0},
    '{ROW_WRITE,  6'd1, 28'd0,          28'd0,          1'b1, 1'b0, 6'd0, 1'b0},
    '{ROW_WRITE,  6'd2, 28'd0,          28'd0,          1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_WRITE,  6'd3, 28'd100,        28'd0,          1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_WRITE,  6'd4, 28'd200,        28'd0,          1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_WRITE,  6'd5, 28'd200,        28'd0,          1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_WRITE,  6'd6, 28'd300,        28'd0,          1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_WRITE,  6'd7, 28'hFFFFFFF,    28'd0,          1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_CONFIG, 6'd0, 28'd400,        28'd8,          1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_CHECK,  6'd0, 28'd0,          28'd0,          1'b1, 1'b0, 6'd0, 1'b0},
    // zero span at zero position fires nothing
    '{ROW_CHECK,  6'd0, 28'd0,          28'd0,          1'b0, 1'b1, 6'd0, 1'b0},
    // position on the duplicate: search lands on the leftmost copy
    '{ROW_CHECK,  6'd0, 28'd200,        28'd1,          1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_CHECK,  6'd0, 28'd350,        28'd100,        1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_CHECK,  6'd0, 28'hFFFFFFF,    28'hFFFFFFF,    1'b0, 1'b0, 6'd0, 1'b0},
    // stop entry after the leading run ends the upward scan
    '{ROW_WRITE,  6'd6, 28'd250,        28'd0,          1'b1, 1'b0, 6'd0, 1'b0},
    '{ROW_CHECK,  6'd0, 28'd150,        28'd300,        1'b0, 1'b0, 6'd0, 1'b0},
    // zero buffer length, no entry reaches the position
    '{ROW_CONFIG, 6'd0, 28'd0,          28'd6,          1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_CHECK,  6'd0, 28'd250,        28'hFFFFFFF,    1'b0, 1'b0, 6'd0, 1'b0},
    // shortest buffer: wrap from the search boundary
    '{ROW_CONFIG, 6'd0, 28'd4,          28'd6,          1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_CHECK,  6'd0, 28'd250,        28'd3,          1'b0, 1'b0, 6'd0, 1'b0}
  };

  play_position_notify_matcher i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .entry_index  (entry_index),
    .entry_offset (entry_offset),
    .entry_is_stop(entry_is_stop),
    .play_position(play_position),
    .span_length  (span_length),
    .is_stopped   (is_stopped),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_index  (event_index),
    .signalled    (signalled),
    .last         (last)
  );

  always #6 clk = ~clk;

  // A stop entry never counts as below any limit
  function automatic bit fires_below(input int i, input logic [OFFSET_BITS:0] limit);
    return !shadow_stop[i] && ({1'b0, shadow_ofs[i]} < limit);
  endfunction

  // Queue the events that one check raises against the shadow table
  function automatic void forecast_events(input logic [OFFSET_BITS-1:0] pos,
                                          input logic [OFFSET_BITS-1:0] span,
                                          input logic stopped);
    int                   n, first, lo, hi, mid, i, j;
    int                   fired[$];
    logic [OFFSET_BITS:0] end_pos, wrap_end;
    event_t               ev;
    n = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
    end_pos = {1'b0, pos} + {1'b0, span};
    if (stopped) begin
      for (i = 0; i < n && shadow_stop[i]; i++) fired.push_back(i);
    end else begin
      first = 0;
      while (first < n && shadow_stop[first]) first++;
      if (first < n) begin
        lo = first;
        hi = n;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (fires_below(mid, {1'b0, pos})) lo = mid + 1;
          else hi = mid;
        end
        for (i = lo; i < n && fires_below(i, end_pos); i++) fired.push_back(i);
        if (ring_len != 0 && end_pos > {1'b0, ring_len}) begin
          wrap_end = end_pos % {1'b0, ring_len};
          for (i = first; i < lo && fires_below(i, wrap_end); i++) fired.push_back(i);
        end
      end
    end
    if (fired.size() == 0) begin
      ev = '{idx: '0, signalled: 1'b0, last: 1'b1};
      due_events.push_back(ev);
    end else begin
      for (j = 0; j < fired.size(); j++) begin
        ev = '{idx: IDX_W'(fired[j]), signalled: 1'b1, last: (j == fired.size() - 1)};
        due_events.push_back(ev);
      end
    end
  endfunction

  // Offer one item, hold it until accepted, then update the shadow
  task automatic offer(input logic req, input logic [IDX_W-1:0] slot,
                       input logic [OFFSET_BITS-1:0] ofs, input logic stop,
                       input logic [OFFSET_BITS-1:0] pos,
                       input logic [OFFSET_BITS-1:0] span,
                       input logic stopped, input bit predict);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= req;
    entry_index   <= slot;
    entry_offset  <= ofs;
    entry_is_stop <= stop;
    play_position <= pos;
    span_length   <= span;
    is_stopped    <= stopped;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (req == REQ_WRITE) begin
      shadow_ofs[slot]  = ofs;
      shadow_stop[slot] = stop;
      written[slot]     = 1'b1;
    end else if (predict) begin
      forecast_events(pos, span, stopped);
    end
  endtask

  // Stop offering, wait for every due event, then let the block go idle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [OFFSET_BITS-1:0] len,
                            input logic [NOTIFY_W-1:0] cnt);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_BUFFER_LENGTH;
    cfg_data  <= CFG_W'(len);
    @(posedge clk);
    cfg_index <= REG_NOTIFY_COUNT;
    cfg_data  <= CFG_W'(cnt);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ring_len    = len;
    entry_count = cnt;
  endtask

  // One random phase: new registers, refreshed table, then a burst of checks
  task automatic run_phase(input int ph);
    logic [OFFSET_BITS-1:0] len, pos, span;
    logic [NOTIFY_W-1:0]    cnt;
    logic [OFFSET_BITS-1:0] new_ofs [TABLE_DEPTH];
    logic                   new_stop [TABLE_DEPTH];
    int                     n_eff, n_stop, n_checks, k;
    int unsigned            scale;
    longint unsigned        step, prev;
    bit                     broken;
    tx_idle_pct = (ph == 1) ? 0 : 8;
    rx_idle_pct = (ph == 1) ? 0 : 8;
    case (ph)
      0: begin
        len = OFS_MAX;
        cnt = NOTIFY_W'(TABLE_DEPTH);
      end
      1: begin
        len = 28'd4;
        cnt = '1;
      end
      default: begin
        case ($urandom_range(9))
          0: len = '0;
          1: len = OFFSET_BITS'($urandom_range(4, 16));
          2: len = OFS_MAX;
          3: len = OFFSET_BITS'($urandom);
          default: len = OFFSET_BITS'($urandom_range(64, 4096));
        endcase
        case ($urandom_range(7))
          0: cnt = '0;
          1: cnt = NOTIFY_W'(TABLE_DEPTH);
          2: cnt = NOTIFY_W'($urandom_range(TABLE_DEPTH + 1, 127));
          default: cnt = NOTIFY_W'($urandom_range(1, TABLE_DEPTH));
        endcase
      end
    endcase
    drain_results();
    write_regs(len, cnt);
    n_eff = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(cnt);

    // Build the table: mostly stop run plus ascending offsets, sometimes garbage
    broken = (ph > 1) && ($urandom_range(4) == 0);
    n_stop = ($urandom_range(9) == 0) ? n_eff : $urandom_range(3);
    scale  = (len == 0) ? OFS_MAX : len;
    step   = scale / (n_eff + 1) + 1;
    prev   = $urandom_range(32'(step));
    for (k = 0; k < TABLE_DEPTH; k++) begin
      if (broken) begin
        new_stop[k] = ($urandom_range(3) == 0);
        new_ofs[k]  = OFFSET_BITS'($urandom);
      end else if (k < n_stop) begin
        new_stop[k] = 1'b1;
        new_ofs[k]  = OFFSET_BITS'($urandom);
      end else begin
        new_stop[k] = 1'b0;
        new_ofs[k]  = (prev > scale - 1) ? OFFSET_BITS'(scale - 1) : OFFSET_BITS'(prev);
        if ($urandom_range(4) != 0) prev += $urandom_range(1, 32'(2 * step));
      end
    end
    for (k = 0; k < TABLE_DEPTH; k++) begin
      if (k < n_eff || !written[k])
        offer(REQ_WRITE, IDX_W'(k), new_ofs[k], new_stop[k], OFFSET_BITS'($urandom),
              OFFSET_BITS'($urandom), 1'($urandom_range(1)), 1'b1);
    end

    // Checks aimed at entry offsets, the extremes and random spans
    n_checks = $urandom_range(15, 40);
    for (k = 0; k < n_checks; k++) begin
      if (ph == 2 && k == 5) hold_asked++;
      case ($urandom_range(9))
        0: pos = OFFSET_BITS'($urandom);
        1: pos = OFS_MAX;
        2: pos = '0;
        3, 4, 5: pos = (n_eff > 0) ?
            shadow_ofs[$urandom_range(n_eff - 1)] + OFFSET_BITS'($urandom_range(2)) - 1'b1 :
            '0;
        default: pos = OFFSET_BITS'($urandom_range(scale - 1));
      endcase
      case ($urandom_range(9))
        0: span = OFFSET_BITS'($urandom);
        1: span = '0;
        2: span = OFS_MAX;
        3, 4: span = (n_eff > 0) ? shadow_ofs[$urandom_range(n_eff - 1)] - pos : '0;
        default: span = OFFSET_BITS'($urandom_range(scale / 3));
      endcase
      offer(REQ_CHECK, IDX_W'($urandom), OFFSET_BITS'($urandom), 1'($urandom_range(1)),
            pos, span, ($urandom_range(9) == 0), 1'b1);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when asked
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_ready    <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (hold_asked != hold_served) begin
      out_ready    <= 1'b0;
      rx_hold_left <= RX_HOLD_CYCLES;
      hold_served  <= hold_asked;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each accepted result with the oldest due event
  always @(posedge clk) begin : check_results
    event_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_events.size() == 0) begin
        $error("unexpected result: event_index %0d signalled %0b last %0b",
               event_index, signalled, last);
        errors++;
      end else begin
        want = due_events.pop_front();
        if (event_index !== want.idx) begin
          $error("event_index: expected %0d, got %0d", want.idx, event_index);
          errors++;
        end
        if (signalled !== want.signalled) begin
          $error("signalled: expected %0b, got %0b", want.signalled, signalled);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb_play_position_notify_matcher: errors");
    $finish;
  end

  initial begin
    dir_row_t row;
    event_t   typed_ev;
    int       ph;
    int       random_start;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed rows
    foreach (directed[r]) begin
      row = directed[r];
      case (row.kind)
        ROW_CONFIG: begin
          drain_results();
          write_regs(row.val_a, row.val_b[NOTIFY_W-1:0]);
        end
        ROW_WRITE: begin
          offer(REQ_WRITE, row.sel, row.val_a, row.flag, '0, '0, 1'b0, 1'b1);
        end
        default: begin
          offer(REQ_CHECK, '0, '0, 1'b0, row.val_a, row.val_b, row.flag, !row.typed);
          if (row.typed) begin
            typed_ev = '{idx: row.t_idx, signalled: row.t_sig, last: 1'b1};
            due_events.push_back(typed_ev);
          end
        end
      endcase
    end

    // Random phases
    random_start = items_sent;
    ph = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      run_phase(ph);
      ph++;
    end

    drain_results();
    if (errors == 0) begin
      $display("tb_play_position_notify_matcher: clean");
    end else begin
      $display("tb_play_position_notify_matcher: errors");
    end
    $finish;
  end

endmodule

// File: files.f
src/ppnm_pkg.sv
src/ppnm_ram.sv
src/play_position_notify_matcher.sv
tb/tb_play_position_notify_matcher.sv
